>>> design/wsts_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and default sizes for the work-stealing task scheduler.
package wsts_pkg;

	localparam int NUM_WORKERS_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TASK_BITS_DEF   = 32;

	typedef enum logic {
		ACT_PUSH  = 1'b0,
		ACT_FETCH = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_PUSHED = 3'd0,
		ST_FULL   = 3'd1,
		ST_OWN    = 3'd2,
		ST_STOLE  = 3'd3,
		ST_NONE   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef struct packed {
		action_t     action;
		logic [2:0]  worker;
		logic [31:0] task_req;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] task_out;
		logic [2:0]  victim;
	} rsp_t;

	typedef struct packed {
		op_t        op;
		status_t    status;
		logic [2:0] victim;
	} cmd_ctl_t;

endpackage

>>> design/work_stealing_task_scheduler_unit.sv
`timescale 1ns / 1ps
// A push, rejected push or empty fetch passes the command queue and the response register;
// a fetch that returns a task also passes the registered store read before the response.
// Throughput: one word per cycle without a store read while rsp_ready holds; a read blocks
// the next one until its task is loaded. A 2-word queue decouples request and response.
// Reset: all queues empty (top and bottom pointers cleared); task store contents are
// undefined and need no clearing pass.
module work_stealing_task_scheduler_unit #(
	parameter int NUM_WORKERS = wsts_pkg::NUM_WORKERS_DEF,
	parameter int QUEUE_DEPTH = wsts_pkg::QUEUE_DEPTH_DEF,
	parameter int TASK_BITS   = wsts_pkg::TASK_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  wsts_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output wsts_pkg::rsp_t rsp
);
	import wsts_pkg::*;

	localparam int AW = $clog2(NUM_WORKERS * QUEUE_DEPTH);

	logic                 cmd_push;
	logic                 cmd_room;
	cmd_ctl_t             in_ctl;
	logic [AW-1:0]        in_addr;
	logic [TASK_BITS-1:0] in_data;
	logic                 cmd_valid;
	logic                 cmd_pop;
	cmd_ctl_t             cmd_ctl;
	logic [AW-1:0]        cmd_addr;
	logic [TASK_BITS-1:0] cmd_data;

	wsts_front #(
		.NUM_WORKERS(NUM_WORKERS),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TASK_BITS  (TASK_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.cmd_push (cmd_push),
		.cmd_room (cmd_room),
		.cmd_ctl  (in_ctl),
		.cmd_addr (in_addr),
		.cmd_data (in_data)
	);

	wsts_cmd_fifo #(
		.ADDR_BITS(AW),
		.TASK_BITS(TASK_BITS)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.room     (cmd_room),
		.push_ctl (in_ctl),
		.push_addr(in_addr),
		.push_data(in_data),
		.valid    (cmd_valid),
		.pop      (cmd_pop),
		.head_ctl (cmd_ctl),
		.head_addr(cmd_addr),
		.head_data(cmd_data)
	);

	wsts_back #(
		.NUM_WORKERS(NUM_WORKERS),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TASK_BITS  (TASK_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd_ctl  (cmd_ctl),
		.cmd_addr (cmd_addr),
		.cmd_data (cmd_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

`ifndef SYNTHESIS
	a_no_task_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_PUSHED || rsp.status == ST_FULL ||
		rsp.status == ST_NONE) |-> (rsp.task_out == '0) && (rsp.victim == '0))
		else $error("non-fetch response carries task or victim");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

	a_read_blocks_next_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop && (cmd_ctl.op == OP_READ) |=> !cmd_pop)
		else $error("command popped while store read in flight");
`endif

endmodule

>>> design/wsts_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
module wsts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

>>> design/wsts_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, owns the per-worker top/bottom pointers, picks the queue.
module wsts_front #(
	parameter int NUM_WORKERS = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int TASK_BITS   = 32
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         req_valid,
	output logic                                         req_ready,
	input  wsts_pkg::req_t                               req,
	output logic                                         cmd_push,
	input  logic                                         cmd_room,
	output wsts_pkg::cmd_ctl_t                           cmd_ctl,
	output logic [$clog2(NUM_WORKERS*QUEUE_DEPTH)-1:0]   cmd_addr,
	output logic [TASK_BITS-1:0]                         cmd_data
);
	import wsts_pkg::*;

	localparam int PW = $clog2(2 * QUEUE_DEPTH);
	localparam int SW = $clog2(QUEUE_DEPTH);
	localparam int WW = $clog2(NUM_WORKERS);
	localparam int AW = $clog2(NUM_WORKERS * QUEUE_DEPTH);
	localparam logic [PW-1:0] PTR_MAX = PW'(2 * QUEUE_DEPTH - 1);
	localparam logic [PW-1:0] QD_P    = PW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] QD_A    = AW'(QUEUE_DEPTH);

	logic [PW-1:0] top_q [NUM_WORKERS];
	logic [PW-1:0] bot_q [NUM_WORKERS];

	logic [NUM_WORKERS-1:0] empty;
	logic [NUM_WORKERS-1:0] full;
	logic [PW:0]            fill [NUM_WORKERS];

	logic [7:0]    wk8;
	logic [WW-1:0] own_w;
	logic          own_ok;
	logic          found;
	logic [WW-1:0] vic;
	logic [7:0]    vic8;
	logic [WW-1:0] sel_w;
	logic [PW-1:0] slot_p;
	logic [PW-1:0] new_ptr;
	logic          upd_bot;
	logic          upd_top;
	logic          fire;
	logic [63:0]   task_w;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PTR_MAX) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		return (p == '0) ? PTR_MAX : p - PW'(1);
	endfunction

	function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] p);
		logic [PW-1:0] s;
		s = (p >= QD_P) ? p - QD_P : p;
		return s[SW-1:0];
	endfunction

	always_comb begin
		for (int i = 0; i < NUM_WORKERS; i++) begin
			empty[i] = (top_q[i] == bot_q[i]);
			fill[i]  = (bot_q[i] >= top_q[i]) ?
				(PW+1)'(bot_q[i]) - (PW+1)'(top_q[i]) :
				(PW+1)'(bot_q[i]) + (PW+1)'(2 * QUEUE_DEPTH) - (PW+1)'(top_q[i]);
			full[i]  = (fill[i] == (PW+1)'(QUEUE_DEPTH));
		end
	end

	assign wk8    = 8'(req.worker);
	assign own_w  = wk8[WW-1:0];
	assign own_ok = (int'(req.worker) < NUM_WORKERS);

	// lowest-index non-empty queue other than the requester's
	always_comb begin
		found = 1'b0;
		vic   = '0;
		for (int i = NUM_WORKERS - 1; i >= 0; i--) begin
			if (!empty[i] && (8'(i) != wk8)) begin
				found = 1'b1;
				vic   = WW'(i);
			end
		end
	end

	assign vic8 = 8'(vic);

	always_comb begin
		cmd_ctl.op     = OP_NONE;
		cmd_ctl.status = ST_NONE;
		cmd_ctl.victim = '0;
		sel_w          = vic;
		slot_p         = '0;
		new_ptr        = '0;
		upd_bot        = 1'b0;
		upd_top        = 1'b0;
		priority if (req.action == ACT_PUSH) begin
			if (!own_ok || full[own_w]) begin
				cmd_ctl.status = ST_FULL;
			end else begin
				cmd_ctl.op     = OP_WRITE;
				cmd_ctl.status = ST_PUSHED;
				sel_w          = own_w;
				slot_p         = bot_q[own_w];
				new_ptr        = ptr_inc(bot_q[own_w]);
				upd_bot        = 1'b1;
			end
		end else if (own_ok && !empty[own_w]) begin
			cmd_ctl.op     = OP_READ;
			cmd_ctl.status = ST_OWN;
			cmd_ctl.victim = req.worker;
			sel_w          = own_w;
			slot_p         = ptr_dec(bot_q[own_w]);
			new_ptr        = slot_p;
			upd_bot        = 1'b1;
		end else if (found) begin
			cmd_ctl.op     = OP_READ;
			cmd_ctl.status = ST_STOLE;
			cmd_ctl.victim = vic8[2:0];
			sel_w          = vic;
			slot_p         = top_q[vic];
			new_ptr        = ptr_inc(top_q[vic]);
			upd_top        = 1'b1;
		end else begin
			// nothing to hand out
			cmd_ctl.status = ST_NONE;
		end
	end

	assign task_w    = 64'(req.task_req);
	assign cmd_data  = task_w[TASK_BITS-1:0];
	assign cmd_addr  = AW'(sel_w) * QD_A + AW'(slot_of(slot_p));
	assign req_ready = cmd_room;
	assign fire      = req_valid && cmd_room;
	assign cmd_push  = fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORKERS; i++) begin
				top_q[i] <= '0;
				bot_q[i] <= '0;
			end
		end else if (fire) begin
			if (upd_bot) begin
				bot_q[sel_w] <= new_ptr;
			end
			if (upd_top) begin
				top_q[sel_w] <= new_ptr;
			end
		end
	end

endmodule

>>> design/wsts_cmd_fifo.sv
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the store back end.
module wsts_cmd_fifo #(
	parameter int ADDR_BITS = 7,
	parameter int TASK_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    room,
	input  wsts_pkg::cmd_ctl_t      push_ctl,
	input  logic [ADDR_BITS-1:0]    push_addr,
	input  logic [TASK_BITS-1:0]    push_data,
	output logic                    valid,
	input  logic                    pop,
	output wsts_pkg::cmd_ctl_t      head_ctl,
	output logic [ADDR_BITS-1:0]    head_addr,
	output logic [TASK_BITS-1:0]    head_data
);
	import wsts_pkg::*;

	cmd_ctl_t             ctl_q  [2];
	logic [ADDR_BITS-1:0] addr_q [2];
	logic [TASK_BITS-1:0] data_q [2];
	logic                 wr_q;
	logic                 rd_q;
	logic [1:0]           cnt_q;

	assign room      = (cnt_q != 2'd2);
	assign valid     = (cnt_q != 2'd0);
	assign head_ctl  = ctl_q[rd_q];
	assign head_addr = addr_q[rd_q];
	assign head_data = data_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wr_q]  <= push_ctl;
			addr_q[wr_q] <= push_addr;
			data_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> design/wsts_back.sv
`timescale 1ns / 1ps
// Back end: runs queued commands against the task store and holds the response word.
module wsts_back #(
	parameter int NUM_WORKERS = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int TASK_BITS   = 32
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cmd_valid,
	output logic                                       cmd_pop,
	input  wsts_pkg::cmd_ctl_t                         cmd_ctl,
	input  logic [$clog2(NUM_WORKERS*QUEUE_DEPTH)-1:0] cmd_addr,
	input  logic [TASK_BITS-1:0]                       cmd_data,
	output logic                                       rsp_valid,
	input  logic                                       rsp_ready,
	output wsts_pkg::rsp_t                             rsp
);
	import wsts_pkg::*;

	localparam int DEPTH = NUM_WORKERS * QUEUE_DEPTH;

	typedef enum logic {
		BK_IDLE,
		BK_WAIT
	} state_t;

	state_t               state_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;
	cmd_ctl_t             hold_q;
	logic                 out_free;
	logic                 rsp_load;
	logic                 ram_we;
	logic                 ram_re;
	logic [TASK_BITS-1:0] ram_rdata;
	logic [63:0]          rd_wide;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign cmd_pop  = cmd_valid && (state_q == BK_IDLE) && out_free;
	assign rsp_load = (state_q == BK_WAIT) || (cmd_pop && (cmd_ctl.op != OP_READ));
	assign ram_we   = cmd_pop && (cmd_ctl.op == OP_WRITE);
	assign ram_re   = cmd_pop && (cmd_ctl.op == OP_READ);
	assign rd_wide  = 64'(ram_rdata);

	wsts_ram #(
		.WIDTH(TASK_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (cmd_addr),
		.wdata(cmd_data),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			hold_q      <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				BK_IDLE: begin
					if (cmd_pop) begin
						if (cmd_ctl.op == OP_READ) begin
							hold_q  <= cmd_ctl;
							state_q <= BK_WAIT;
						end else begin
							rsp_q.status   <= cmd_ctl.status;
							rsp_q.task_out <= '0;
							rsp_q.victim   <= cmd_ctl.victim;
							rsp_valid_q    <= 1'b1;
						end
					end
				end
				BK_WAIT: begin
					rsp_q.status   <= hold_q.status;
					rsp_q.task_out <= rd_wide[31:0];
					rsp_q.victim   <= hold_q.victim;
					rsp_valid_q    <= 1'b1;
					state_q        <= BK_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
